// ===== src/atu3d_pkg.sv =====
// ----------------------------------------------------------------------------
// atu3d_pkg
// Shared types and constants of the 3D affine transform unit: fixed point
// element types, the 3x3 matrix and 3-vector types and the operation codes.
// ----------------------------------------------------------------------------
package atu3d_pkg;

    localparam int MAT_W   = 16;
    localparam int VEC_W   = 24;
    localparam int FRAC_SH = 12;

    typedef logic signed [MAT_W-1:0] t_melem;
    typedef logic signed [VEC_W-1:0] t_velem;
    typedef t_melem [2:0][2:0] t_mat;
    typedef t_velem [2:0] t_vec;

    typedef enum logic [2:0] {
        OP_LOAD          = 3'd0,
        OP_COMPOSE_AFTER = 3'd1,
        OP_COMPOSE_BEFORE= 3'd2,
        OP_APPLY         = 3'd3,
        OP_COMBINE       = 3'd4
    } t_op;

    localparam t_mat MAT_IDENT = {
        16'h1000, 16'h0000, 16'h0000,
        16'h0000, 16'h1000, 16'h0000,
        16'h0000, 16'h0000, 16'h1000
    };

endpackage

// ===== src/affine_transform_unit_3d_top.sv =====
// ----------------------------------------------------------------------------
// affine_transform_unit_3d_top
// An input beat is registered in the input stage, its result in the output
// stage. Throughput: one beat per cycle while m_axis_tready does not stall the
// output; the held transform is read and rewritten in the same cycle, so each
// beat sees the state left by the one before. Reset (synchronous, active
// low): identity matrix, zero translation, both pipeline stages empty.
// ----------------------------------------------------------------------------
module affine_transform_unit_3d_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // matrix_row_0, matrix_row_1, matrix_row_2, vec_x, vec_y, vec_z
    input  logic [215:0] s_axis_tdata,
    // operation
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z
    output logic [71:0]  m_axis_tdata,
    // saturated
    output logic [0:0]   m_axis_tuser
);
    import atu3d_pkg::*;

    logic        r_in_vld;
    logic [2:0]  r_op;
    t_mat        r_m;
    t_vec        r_v;

    logic        r_out_vld;
    t_vec        r_res;
    logic        r_sat;

    t_mat        r_mat;
    t_vec        r_off;

    t_mat        n_mat;
    t_vec        n_off;
    t_vec        n_res;
    logic        n_sat;

    logic        en;
    logic        adv;
    logic        is_after;

    t_mat        mm_a;
    t_mat        mm_b;
    t_mat        mm_c;
    logic        mm_sat;
    t_mat        mv_a;
    t_vec        mv_p;
    t_vec        mv_t;
    t_vec        mv_r;
    logic        mv_sat;
    t_vec        add_r;
    logic        add_sat;

    assign en            = !r_out_vld || m_axis_tready;
    assign adv           = r_in_vld && en;
    assign s_axis_tready = en || !r_in_vld;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op <= s_axis_tuser;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m[i][j] <= s_axis_tdata[i*48 + j*16 +: 16];
                end
                r_v[i] <= s_axis_tdata[144 + i*24 +: 24];
            end
        end
    end

    // operand selection: compose after swaps the roles of held and input
    assign is_after = (r_op == OP_COMPOSE_AFTER);
    assign mm_a     = is_after ? r_m   : r_mat;
    assign mm_b     = is_after ? r_mat : r_m;
    assign mv_a     = is_after ? r_m   : r_mat;
    assign mv_p     = is_after ? r_off : r_v;
    assign mv_t     = is_after ? r_v   : r_off;

    atu3d_matmul u_matmul (
        .i_a   (mm_a),
        .i_b   (mm_b),
        .o_c   (mm_c),
        .o_sat (mm_sat)
    );

    atu3d_matvec u_matvec (
        .i_a   (mv_a),
        .i_p   (mv_p),
        .i_t   (mv_t),
        .o_r   (mv_r),
        .o_sat (mv_sat)
    );

    // translation sum for combine
    always_comb begin
        logic signed [VEC_W:0] s;
        add_sat = 1'b0;
        add_r   = '0;
        for (int i = 0; i < 3; i++) begin
            s = {r_off[i][VEC_W-1], r_off[i]} + {r_v[i][VEC_W-1], r_v[i]};
            if (s[VEC_W] != s[VEC_W-1]) begin
                add_r[i] = s[VEC_W] ? 24'h800000 : 24'h7fffff;
                add_sat  = 1'b1;
            end else begin
                add_r[i] = s[VEC_W-1:0];
            end
        end
    end

    always_comb begin
        n_mat = r_mat;
        n_off = r_off;
        n_sat = 1'b0;
        case (r_op)
            OP_LOAD: begin
                n_mat = r_m;
                n_off = r_v;
            end
            OP_COMPOSE_AFTER, OP_COMPOSE_BEFORE: begin
                n_mat = mm_c;
                n_off = mv_r;
                n_sat = mm_sat || mv_sat;
            end
            OP_APPLY: begin
                n_sat = mv_sat;
            end
            OP_COMBINE: begin
                n_mat = mm_c;
                n_off = add_r;
                n_sat = mm_sat || add_sat;
            end
            default: begin
                n_sat = 1'b0;
            end
        endcase
        n_res = (r_op == OP_APPLY) ? mv_r : n_off;
    end

    // held transform and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_mat     <= MAT_IDENT;
            r_off     <= '0;
        end else begin
            if (en) begin
                r_out_vld <= r_in_vld;
            end
            if (adv) begin
                r_mat <= n_mat;
                r_off <= n_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_res[2], r_res[1], r_res[0]};
    assign m_axis_tuser  = r_sat;

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_mat == MAT_IDENT) && (r_off == '0) && !r_out_vld)
        else $error("held transform not cleared by reset");

    a_apply_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_op == OP_APPLY) |=> $stable(r_mat) && $stable(r_off))
        else $error("apply changed the held transform");

    a_load_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_op == OP_LOAD) |=> !r_sat && (r_off == $past(r_v)))
        else $error("load beat flagged or offset not taken");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_vld && r_out_vld && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    a_unused_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_op != OP_LOAD) && (r_op != OP_COMPOSE_AFTER)
            && (r_op != OP_COMPOSE_BEFORE) && (r_op != OP_APPLY)
            && (r_op != OP_COMBINE)
        |=> $stable(r_mat) && $stable(r_off) && !r_sat)
        else $error("unused operation code changed state");

endmodule

// ===== src/atu3d_matmul.sv =====
// ----------------------------------------------------------------------------
// atu3d_matmul
// 3x3 by 3x3 product of Q3.12 matrices, nine parallel multiply-add trees,
// each rounded half up to Q3.12 and saturated to 16 bits.
// ----------------------------------------------------------------------------
module atu3d_matmul (
    input  atu3d_pkg::t_mat i_a,
    input  atu3d_pkg::t_mat i_b,
    output atu3d_pkg::t_mat o_c,
    output logic            o_sat
);
    import atu3d_pkg::*;

    localparam int PROD_W = 2 * MAT_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RND_W  = ACC_W - FRAC_SH;

    always_comb begin
        logic signed [PROD_W-1:0] prod;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  biased;
        logic signed [RND_W-1:0]  rnd;
        o_sat = 1'b0;
        o_c   = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = '0;
                for (int k = 0; k < 3; k++) begin
                    prod = $signed(i_a[i][k]) * $signed(i_b[k][j]);
                    acc  = acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
                end
                biased = acc + ACC_W'(2048);
                rnd    = $signed(biased[ACC_W-1:FRAC_SH]);
                // clip to the q3.12 range
                if (rnd > $signed(RND_W'(32767))) begin
                    o_c[i][j] = 16'h7fff;
                    o_sat     = 1'b1;
                end else if (rnd < -$signed(RND_W'(32768))) begin
                    o_c[i][j] = 16'h8000;
                    o_sat     = 1'b1;
                end else begin
                    o_c[i][j] = rnd[MAT_W-1:0];
                end
            end
        end
    end

endmodule

// ===== src/atu3d_matvec.sv =====
// ----------------------------------------------------------------------------
// atu3d_matvec
// Q3.12 matrix times Q15.8 vector plus Q15.8 translation; summed products
// rounded half up to Q15.8, translation added, result saturated once to 24 bits.
// ----------------------------------------------------------------------------
module atu3d_matvec (
    input  atu3d_pkg::t_mat i_a,
    input  atu3d_pkg::t_vec i_p,
    input  atu3d_pkg::t_vec i_t,
    output atu3d_pkg::t_vec o_r,
    output logic            o_sat
);
    import atu3d_pkg::*;

    localparam int PROD_W = MAT_W + VEC_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RND_W  = ACC_W - FRAC_SH;
    localparam int SUM_W  = RND_W + 1;

    always_comb begin
        logic signed [PROD_W-1:0] prod;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  biased;
        logic signed [RND_W-1:0]  rnd;
        logic signed [SUM_W-1:0]  sum;
        o_sat = 1'b0;
        o_r   = '0;
        for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int k = 0; k < 3; k++) begin
                prod = $signed(i_a[i][k]) * $signed(i_p[k]);
                acc  = acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
            end
            biased = acc + ACC_W'(2048);
            rnd    = $signed(biased[ACC_W-1:FRAC_SH]);
            sum    = {rnd[RND_W-1], rnd}
                   + {{(SUM_W-VEC_W){i_t[i][VEC_W-1]}}, i_t[i]};
            // clip to the q15.8 range
            if (sum > $signed(SUM_W'(8388607))) begin
                o_r[i] = 24'h7fffff;
                o_sat  = 1'b1;
            end else if (sum < -$signed(SUM_W'(8388608))) begin
                o_r[i] = 24'h800000;
                o_sat  = 1'b1;
            end else begin
                o_r[i] = sum[VEC_W-1:0];
            end
        end
    end

endmodule
